### hw/rtl/csds_pkg.sv
package csds_pkg;

    // Configuration port geometry: three 32-bit registers at byte offsets 0, 4 and 8.
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_REGION_LENGTH   = 2'd0;
    localparam logic [1:0] REG_TARGET_ID       = 2'd1;
    localparam logic [1:0] REG_TARGET_INSTANCE = 2'd2;

    // Byte role codes carried on tuser.
    localparam logic [1:0] ROLE_ID      = 2'd0;
    localparam logic [1:0] ROLE_LENGTH  = 2'd1;
    localparam logic [1:0] ROLE_PAYLOAD = 2'd2;
    localparam logic [1:0] ROLE_IGNORED = 2'd3;

    // Chunk id value that marks "no chunk".
    localparam logic [7:0] ID_EMPTY = 8'hFF;

    // Width of the 24-bit offset and length fields.
    localparam int FIELD_W = 24;

    // Number of region length bits the walk keeps.
    localparam int REGION_ADDR_BITS = 24;

    typedef struct packed {
        logic [FIELD_W-1:0] region_length;
        logic [7:0]         target_id;
        logic [15:0]        target_instance;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         byte_role;
        logic [7:0]         owner_id;
        logic [FIELD_W-1:0] chunk_start;
        logic [FIELD_W-1:0] chunk_length;
        logic               target_hit;
        logic               region_done;
        logic               found;
        logic [FIELD_W-1:0] match_start;
        logic [FIELD_W-1:0] match_length;
        logic [FIELD_W-1:0] id_count;
        logic               stopped_early;
    } result_t;

endpackage

### hw/rtl/csds_cfg.sv
module csds_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [csds_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [csds_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [csds_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    output csds_pkg::cfg_t                    cfg
);
    import csds_pkg::*;

    logic [FIELD_W-1:0] region_reg;
    logic [FIELD_W-1:0] region_next;
    logic [7:0]         target_id_reg;
    logic [7:0]         target_id_next;
    logic [15:0]        instance_reg;
    logic [15:0]        instance_next;
    logic               wr_en;
    logic [1:0]         reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel & penable & pwrite & pready;
    assign reg_index = paddr[3:2];

    // Register writes; the region length keeps only the address bits the walk uses.
    always_comb begin
        region_next    = region_reg;
        target_id_next = target_id_reg;
        instance_next  = instance_reg;
        if (wr_en) begin
            case (reg_index)
                REG_REGION_LENGTH: begin
                    region_next = FIELD_W'(REGION_ADDR_BITS'(pwdata[FIELD_W-1:0]));
                end
                REG_TARGET_ID: begin
                    target_id_next = pwdata[7:0];
                end
                REG_TARGET_INSTANCE: begin
                    instance_next = pwdata[15:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_reg    <= '0;
            target_id_reg <= '0;
            instance_reg  <= 16'd1;
        end else begin
            region_reg    <= region_next;
            target_id_reg <= target_id_next;
            instance_reg  <= instance_next;
        end
    end

    // Read back.
    always_comb begin
        case (reg_index)
            REG_REGION_LENGTH:   prdata = CFG_DATA_W'(region_reg);
            REG_TARGET_ID:       prdata = CFG_DATA_W'(target_id_reg);
            REG_TARGET_INSTANCE: prdata = CFG_DATA_W'(instance_reg);
            default:             prdata = '0;
        endcase
    end

    assign cfg.region_length   = region_reg;
    assign cfg.target_id       = target_id_reg;
    assign cfg.target_instance = instance_reg;

endmodule

### hw/rtl/csds_walk.sv
module csds_walk (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  logic [7:0]           data_byte,
    input  csds_pkg::cfg_t       cfg,
    output csds_pkg::result_t    result
);
    import csds_pkg::*;

    localparam int AW   = REGION_ADDR_BITS;
    localparam int AW1  = AW + 1;
    localparam int SUMW = 33;

    // Parse phase codes.
    localparam logic [2:0] PH_ID   = 3'd0;
    localparam logic [2:0] PH_LEN  = 3'd1;
    localparam logic [2:0] PH_LONG = 3'd2;
    localparam logic [2:0] PH_PAY  = 3'd3;

    logic [AW-1:0]      pos_reg,         pos_next;
    logic [2:0]         phase_reg,       phase_next;
    logic [31:0]        word_reg,        word_next;
    logic [1:0]         lbl_reg,         lbl_next;
    logic [7:0]         cur_id_reg,      cur_id_next;
    logic [AW-1:0]      cur_start_reg,   cur_start_next;
    logic [FIELD_W-1:0] pay_left_reg,    pay_left_next;
    logic [FIELD_W-1:0] occ_reg,         occ_next;
    logic               found_reg,       found_next;
    logic [AW-1:0]      found_start_reg, found_start_next;
    logic [FIELD_W-1:0] found_len_reg,   found_len_next;
    logic               stop_reg,        stop_next;

    logic [AW-1:0]      lim;
    logic [AW1-1:0]     lim_ext;
    logic [AW1-1:0]     pos_plus1;
    logic [AW1-1:0]     pos_plus2;
    logic [AW1-1:0]     pos_plus4;
    logic [SUMW-1:0]    hdr_end;
    logic               hdr_go;
    logic [30:0]        hdr_len;
    logic [1:0]         lbl_eff;
    logic [FIELD_W-1:0] pay_dec;
    logic [15:0]        inst_eff;
    logic [AW-1:0]      cs;

    assign lim       = AW'(cfg.region_length);
    assign lim_ext   = {1'b0, lim};
    assign pos_plus1 = {1'b0, pos_reg} + AW1'(1);
    assign pos_plus2 = {1'b0, pos_reg} + AW1'(2);
    assign pos_plus4 = {1'b0, pos_reg} + AW1'(4);
    assign inst_eff  = (cfg.target_instance == 16'd0) ? 16'd1 : cfg.target_instance;

    // One byte of the walk: header decode, payload count, occurrence search.
    always_comb begin
        pos_next         = pos_reg;
        phase_next       = phase_reg;
        word_next        = word_reg;
        lbl_next         = lbl_reg;
        cur_id_next      = cur_id_reg;
        cur_start_next   = cur_start_reg;
        pay_left_next    = pay_left_reg;
        occ_next         = occ_reg;
        found_next       = found_reg;
        found_start_next = found_start_reg;
        found_len_next   = found_len_reg;
        stop_next        = stop_reg;
        hdr_go           = 1'b0;
        hdr_len          = '0;
        hdr_end          = '0;
        lbl_eff          = lbl_reg;
        pay_dec          = pay_left_reg;
        cs               = '0;
        result           = '0;
        result.byte_role = ROLE_IGNORED;
        result.owner_id  = ID_EMPTY;

        if (lim != '0) begin
            if (!stop_reg) begin
                case (phase_reg)
                    PH_ID: begin
                        // A chunk needs at least an id and a length byte.
                        if (pos_plus2 > lim_ext) begin
                            stop_next = 1'b1;
                        end else begin
                            cur_id_next      = data_byte;
                            result.byte_role = ROLE_ID;
                            result.owner_id  = data_byte;
                            phase_next       = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        result.byte_role = ROLE_LENGTH;
                        result.owner_id  = cur_id_reg;
                        word_next        = 32'(data_byte);
                        if (data_byte[0]) begin
                            // Long header: three more length bytes must fit.
                            if (pos_plus4 > lim_ext) begin
                                stop_next = 1'b1;
                            end else begin
                                lbl_next   = 2'd3;
                                phase_next = PH_LONG;
                            end
                        end else begin
                            hdr_go  = 1'b1;
                            hdr_len = 31'(data_byte[7:1]);
                        end
                    end
                    PH_LONG: begin
                        result.byte_role = ROLE_LENGTH;
                        result.owner_id  = cur_id_reg;
                        lbl_eff = (lbl_reg == 2'd0) ? 2'd1 : lbl_reg;
                        // Little-endian: the first extension byte lands in bits 15:8.
                        case (lbl_eff)
                            2'd3:    word_next = word_reg | {16'd0, data_byte, 8'd0};
                            2'd2:    word_next = word_reg | {8'd0, data_byte, 16'd0};
                            default: word_next = word_reg | {data_byte, 24'd0};
                        endcase
                        lbl_next = lbl_eff - 2'd1;
                        if (lbl_eff == 2'd1) begin
                            hdr_go  = 1'b1;
                            hdr_len = word_next[31:1];
                        end
                    end
                    default: begin
                        result.byte_role    = ROLE_PAYLOAD;
                        result.owner_id     = cur_id_reg;
                        cs                  = cur_start_reg;
                        result.chunk_length = FIELD_W'(word_reg[31:1]);
                        result.target_hit   = found_reg && (found_start_reg == cur_start_reg);
                        if (pay_left_reg != '0) begin
                            pay_dec = pay_left_reg - FIELD_W'(1);
                        end
                        pay_left_next = pay_dec;
                        if (pay_dec == '0) begin
                            phase_next = PH_ID;
                        end
                    end
                endcase
            end

            // Header complete: the payload must lie inside the region.
            if (hdr_go) begin
                hdr_end = SUMW'(pos_reg) + SUMW'(1) + SUMW'(hdr_len);
                if (hdr_end > SUMW'(lim)) begin
                    stop_next = 1'b1;
                end else begin
                    cur_start_next      = pos_plus1[AW-1:0];
                    pay_left_next       = FIELD_W'(hdr_len);
                    cs                  = pos_plus1[AW-1:0];
                    result.chunk_length = FIELD_W'(hdr_len);
                    if (cur_id_reg == cfg.target_id) begin
                        if (occ_reg != {FIELD_W{1'b1}}) begin
                            occ_next = occ_reg + FIELD_W'(1);
                        end
                        if (!found_reg && occ_next == FIELD_W'(inst_eff)) begin
                            found_next        = 1'b1;
                            found_start_next  = pos_plus1[AW-1:0];
                            found_len_next    = FIELD_W'(hdr_len);
                            result.target_hit = 1'b1;
                        end
                    end
                    phase_next = (hdr_len != '0) ? PH_PAY : PH_ID;
                end
            end

            // Last byte of the region: report the summary and restart the walk.
            if (pos_plus1 >= lim_ext) begin
                result.region_done   = 1'b1;
                result.found         = found_next;
                result.match_start   = found_next ? FIELD_W'(found_start_next) : '0;
                result.match_length  = found_next ? found_len_next : '0;
                result.id_count      = occ_next;
                result.stopped_early = stop_next;
                pos_next         = '0;
                phase_next       = PH_ID;
                word_next        = '0;
                lbl_next         = '0;
                cur_id_next      = ID_EMPTY;
                cur_start_next   = '0;
                pay_left_next    = '0;
                occ_next         = '0;
                found_next       = 1'b0;
                found_start_next = '0;
                found_len_next   = '0;
                stop_next        = 1'b0;
            end else begin
                pos_next = pos_plus1[AW-1:0];
            end
        end

        result.chunk_start = FIELD_W'(cs);
    end

    // Walk state advances once per transfer out of the input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= '0;
            phase_reg       <= PH_ID;
            word_reg        <= '0;
            lbl_reg         <= '0;
            cur_id_reg      <= ID_EMPTY;
            cur_start_reg   <= '0;
            pay_left_reg    <= '0;
            occ_reg         <= '0;
            found_reg       <= 1'b0;
            found_start_reg <= '0;
            found_len_reg   <= '0;
            stop_reg        <= 1'b0;
        end else if (advance) begin
            pos_reg         <= pos_next;
            phase_reg       <= phase_next;
            word_reg        <= word_next;
            lbl_reg         <= lbl_next;
            cur_id_reg      <= cur_id_next;
            cur_start_reg   <= cur_start_next;
            pay_left_reg    <= pay_left_next;
            occ_reg         <= occ_next;
            found_reg       <= found_next;
            found_start_reg <= found_start_next;
            found_len_reg   <= found_len_next;
            stop_reg        <= stop_next;
        end
    end

endmodule

### hw/rtl/chunk_stream_deframer_search.sv
// Chunk stream deframer with id search. Each byte of a region enters on the s_ stream and
// leaves on the m_ stream tagged with its role (id, length, payload or ignored) and the
// offset and length of its chunk; the region's last byte carries tlast and the summary:
// the count of well-formed chunks with target_id and the start and length of occurrence
// target_instance. The block takes one byte every clock cycle when not stalled and has one
// input register and one output register, with the header decode and the occurrence counter
// between them. Backpressure on m_tready stops the input only when both registers are full.
// Configuration registers are to be written over the APB port while the stream is idle, which
// the block does not enforce; a byte position at or past a shortened region end ends the region.
module chunk_stream_deframer_search (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] data_byte
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] owner_id, [31:8] chunk_start, [55:32] chunk_length, [56] target_hit,
    // [57] found, [81:58] match_start, [105:82] match_length, [129:106] id_count,
    // [130] stopped_early, [135:131] zero
    output logic [135:0]                      m_tdata,
    output logic [1:0]                        m_tuser,   // [1:0] byte_role
    output logic                              m_tlast,   // region_done
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [csds_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [csds_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [csds_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import csds_pkg::*;

    cfg_t       cfg;
    result_t    step_result;
    result_t    out_res_reg;
    result_t    out_res_next;
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg,  in_byte_next;
    logic       out_valid_reg, out_valid_next;
    logic       advance;

    csds_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    csds_walk u_walk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .data_byte (in_byte_reg),
        .cfg       (cfg),
        .result    (step_result)
    );

    // A byte moves from the input register to the output register when the latter frees up.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
            in_byte_next  = s_tdata;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (advance) begin
            out_valid_next = 1'b1;
            out_res_next   = step_result;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
        out_res_reg <= out_res_next;
    end

    // Output packing.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.byte_role;
    assign m_tlast  = out_res_reg.region_done;
    assign m_tdata  = {5'd0,
                       out_res_reg.stopped_early,
                       out_res_reg.id_count,
                       out_res_reg.match_length,
                       out_res_reg.match_start,
                       out_res_reg.found,
                       out_res_reg.target_hit,
                       out_res_reg.chunk_length,
                       out_res_reg.chunk_start,
                       out_res_reg.owner_id};

    // Ignored bytes belong to no chunk.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_res_reg.byte_role == ROLE_IGNORED) |->
        (out_res_reg.owner_id == ID_EMPTY && out_res_reg.chunk_length == '0
         && !out_res_reg.target_hit))
        else $error("ignored byte carries chunk fields");

    // The summary is only given on the region's last byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_res_reg.region_done) |->
        (out_res_reg.id_count == '0 && !out_res_reg.found && !out_res_reg.stopped_early))
        else $error("summary fields set before the end of the region");

    // No match position is reported without a match.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_res_reg.found) |->
        (out_res_reg.match_start == '0 && out_res_reg.match_length == '0))
        else $error("match fields set without a found occurrence");

    // A found occurrence implies at least one counted chunk.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_res_reg.found) |-> (out_res_reg.id_count != '0))
        else $error("found occurrence with zero id count");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import csds_pkg::*;

    localparam logic [23:0] MASK24 = 24'hFF_FFFF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_BYTES = 1650;

    // Tracks the chunk walk and holds the byte tags the block should produce.
    class chunk_walk_scoreboard;
        typedef enum int {WALK_ID, WALK_LEN, WALK_LONG, WALK_PAYLOAD} walk_phase_t;

        logic [23:0] region_len;
        logic [7:0]  want_id;
        logic [15:0] want_inst;

        logic [23:0] position;
        walk_phase_t phase;
        logic [31:0] len_word;
        int          long_left;
        logic [7:0]  cur_id;
        logic [23:0] cur_start;
        logic [23:0] pay_left;
        logic [23:0] id_seen;
        bit          found;
        logic [23:0] found_start;
        logic [23:0] found_len;
        bit          stopped;

        result_t expected_tags[$];
        int      errors;

        function new();
            region_len = '0;
            want_id = '0;
            want_inst = 16'd1;
            errors = 0;
            clear_walk();
        endfunction

        function void clear_walk();
            position = '0;
            phase = WALK_ID;
            len_word = '0;
            long_left = 0;
            cur_id = ID_EMPTY;
            cur_start = '0;
            pay_left = '0;
            id_seen = '0;
            found = 0;
            found_start = '0;
            found_len = '0;
            stopped = 0;
        endfunction

        function void write_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_REGION_LENGTH:   region_len = value[23:0];
                REG_TARGET_ID:       want_id = value[7:0];
                REG_TARGET_INSTANCE: want_inst = value[15:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_tags.size();
        endfunction

        // The last header byte has arrived: check the fit and count the chunk.
        function void close_header(longint unsigned p, longint unsigned len,
                                   longint unsigned lim, inout result_t r);
            longint unsigned inst;
            inst = (want_inst == 0) ? 1 : want_inst;
            if (p + 1 + len > lim) begin
                stopped = 1;
                return;
            end
            cur_start = 24'(p + 1);
            pay_left = 24'(len);
            r.chunk_start = cur_start;
            r.chunk_length = 24'(len);
            if (cur_id == want_id) begin
                if (id_seen != MASK24) id_seen++;
                if (!found && id_seen == inst) begin
                    found = 1;
                    found_start = cur_start;
                    found_len = 24'(len);
                    r.target_hit = 1'b1;
                end
            end
            phase = (len != 0) ? WALK_PAYLOAD : WALK_ID;
        endfunction

        // Works out the tag of one accepted byte and queues it.
        function void predict_byte_tag(logic [7:0] b);
            result_t r;
            longint unsigned lim;
            longint unsigned p;
            r = '0;
            r.byte_role = ROLE_IGNORED;
            r.owner_id = ID_EMPTY;
            lim = region_len;
            p = position;
            if (lim != 0) begin
                if (!stopped) begin
                    case (phase)
                        WALK_ID: begin
                            if (p + 2 > lim) begin
                                stopped = 1;
                            end else begin
                                cur_id = b;
                                r.byte_role = ROLE_ID;
                                r.owner_id = b;
                                phase = WALK_LEN;
                            end
                        end
                        WALK_LEN: begin
                            r.byte_role = ROLE_LENGTH;
                            r.owner_id = cur_id;
                            len_word = {24'd0, b};
                            if (b[0]) begin
                                if (p + 4 > lim) begin
                                    stopped = 1;
                                end else begin
                                    long_left = 3;
                                    phase = WALK_LONG;
                                end
                            end else begin
                                close_header(p, 64'(b >> 1), lim, r);
                            end
                        end
                        WALK_LONG: begin
                            r.byte_role = ROLE_LENGTH;
                            r.owner_id = cur_id;
                            if (long_left == 0) long_left = 1;
                            len_word = len_word | ({24'd0, b} << (8 * (4 - long_left)));
                            long_left--;
                            if (long_left == 0) close_header(p, 64'(len_word >> 1), lim, r);
                        end
                        default: begin
                            r.byte_role = ROLE_PAYLOAD;
                            r.owner_id = cur_id;
                            r.chunk_start = cur_start;
                            r.chunk_length = 24'(len_word >> 1);
                            r.target_hit = found && (found_start == cur_start);
                            if (pay_left != 0) pay_left--;
                            if (pay_left == 0) phase = WALK_ID;
                        end
                    endcase
                end
                // The region's last byte carries the summary and restarts the walk.
                if (p + 1 >= lim) begin
                    r.region_done = 1'b1;
                    r.found = found;
                    r.match_start = found ? found_start : 24'd0;
                    r.match_length = found ? found_len : 24'd0;
                    r.id_count = id_seen;
                    r.stopped_early = stopped;
                    clear_walk();
                end else begin
                    position = 24'(p + 1);
                end
            end
            expected_tags = {expected_tags, r};
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s is %0h, should be %0h", name, got, want));
        endtask

        task check_result(result_t got);
            result_t want;
            if (expected_tags.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                want = expected_tags[0];
                expected_tags.delete(0);
                compare_field("byte_role", got.byte_role, want.byte_role);
                compare_field("owner_id", got.owner_id, want.owner_id);
                compare_field("chunk_start", got.chunk_start, want.chunk_start);
                compare_field("chunk_length", got.chunk_length, want.chunk_length);
                compare_field("target_hit", got.target_hit, want.target_hit);
                compare_field("region_done", got.region_done, want.region_done);
                compare_field("found", got.found, want.found);
                compare_field("match_start", got.match_start, want.match_start);
                compare_field("match_length", got.match_length, want.match_length);
                compare_field("id_count", got.id_count, want.id_count);
                compare_field("stopped_early", got.stopped_early, want.stopped_early);
            end
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // [7:0] data_byte
    logic                  m_tvalid;
    logic                  m_tready;
    // [7:0] owner_id, [31:8] chunk_start, [55:32] chunk_length, [56] target_hit,
    // [57] found, [81:58] match_start, [105:82] match_length, [129:106] id_count,
    // [130] stopped_early, [135:131] zero
    logic [135:0]          m_tdata;
    logic [1:0]            m_tuser;   // [1:0] byte_role
    logic                  m_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    chunk_walk_scoreboard sb = new();

    int          cycles = 0;
    int          bytes_sent = 0;
    bit          tx_calm = 0;
    bit          rx_calm = 0;
    int          rx_hold = 0;
    int          rx_cycles = 0;
    logic [7:0]  tid_now = '0;
    result_t     seen_tag;

    chunk_stream_deframer_search dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // Run limit.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Idle gaps: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result side stalls, with calm stretches where it never stalls.
    always @(negedge aclk) begin
        rx_cycles++;
        if (rx_cycles % 256 == 0) rx_calm = ($urandom_range(0, 3) == 0);
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold--;
        end else begin
            m_tready <= 1'b1;
            if (!rx_calm && $urandom_range(0, 4) == 0) rx_hold = pick_gap();
        end
    end

    // Every result transfer is checked against the oldest expected tag.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_tag.byte_role     = m_tuser;
            seen_tag.owner_id      = m_tdata[7:0];
            seen_tag.chunk_start   = m_tdata[31:8];
            seen_tag.chunk_length  = m_tdata[55:32];
            seen_tag.target_hit    = m_tdata[56];
            seen_tag.region_done   = m_tlast;
            seen_tag.found         = m_tdata[57];
            seen_tag.match_start   = m_tdata[81:58];
            seen_tag.match_length  = m_tdata[105:82];
            seen_tag.id_count      = m_tdata[129:106];
            seen_tag.stopped_early = m_tdata[130];
            sb.check_result(seen_tag);
        end
    end

    // One byte transfer on the input side, after a random gap.
    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        sb.predict_byte_tag(b);
        bytes_sent++;
    endtask

    task automatic send_bytes(logic [7:0] q[$]);
        foreach (q[i]) send_byte(q[i]);
    endtask

    // Stop sending and wait until every expected transfer has come out.
    task automatic drain_stream();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_cfg(logic [1:0] idx, logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_register(idx, value);
        if (idx == REG_TARGET_ID) tid_now = value[7:0];
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Builds one region of chunks, mostly well-formed, with some noise,
    // overruns and headers that do not fit.
    function automatic void build_region(int size, logic [7:0] tid, ref logic [7:0] q[$]);
        int rem;
        int room;
        int hdr;
        int r;
        bit is_long;
        longint unsigned len;
        logic [31:0] word;
        q.delete();
        while (q.size() < size) begin
            rem = size - q.size();
            if (rem < 2 || $urandom_range(0, 19) == 0) begin
                q = {q, 8'($urandom_range(0, 255))};
                continue;
            end
            r = $urandom_range(0, 9);
            q = {q, (r < 5 ? tid : (r < 7 ? tid ^ 8'd1 : 8'($urandom_range(0, 255))))};
            is_long = ($urandom_range(0, 3) == 0);
            hdr = is_long ? 5 : 2;
            room = (rem > hdr) ? rem - hdr : 0;
            if ($urandom_range(0, 11) == 0) begin
                if ($urandom_range(0, 3) == 0) len = 64'($urandom & 32'h7FFF_FFFF);
                else len = 64'(room + $urandom_range(1, 300));
            end else begin
                len = 64'($urandom_range(0, room < 40 ? room : 40));
            end
            if (len > 127) is_long = 1;
            if (is_long) begin
                word = 32'(len << 1) | 32'd1;
                for (int k = 0; k < 4; k++) q = {q, word[8*k +: 8]};
            end else begin
                q = {q, 8'(len << 1)};
            end
            for (longint unsigned k = 0; k < len && q.size() < size; k++)
                q = {q, 8'($urandom_range(0, 255))};
        end
        while (q.size() > size) q.delete(q.size() - 1);
    endfunction

    initial begin
        logic [7:0] region[$];
        logic [31:0] value;
        int phase_no;
        int size;
        int r;

        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        aresetn = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Zero region length after reset: bytes are ignored, no summary.
        send_bytes('{8'h00, 8'hFF});
        drain_stream();

        // Short and long headers, first occurrence via instance zero, and a
        // single leftover byte that stops the walk.
        write_cfg(REG_REGION_LENGTH, 32'd12);
        write_cfg(REG_TARGET_ID, 32'h07);
        write_cfg(REG_TARGET_INSTANCE, 32'd0);
        send_bytes('{8'h07, 8'h04, 8'hAA, 8'hBB, 8'h07, 8'h05, 8'h00, 8'h00, 8'h00,
                     8'h5A, 8'hA5, 8'h3C});
        drain_stream();

        // Long header that does not fit, at the highest id and instance.
        write_cfg(REG_REGION_LENGTH, 32'd4);
        write_cfg(REG_TARGET_ID, 32'd254);
        write_cfg(REG_TARGET_INSTANCE, 32'd65535);
        send_bytes('{8'hFE, 8'h01, 8'h00, 8'h00});
        drain_stream();

        // Empty payload, then a payload that overruns the region.
        write_cfg(REG_REGION_LENGTH, 32'd6);
        write_cfg(REG_TARGET_ID, 32'd0);
        write_cfg(REG_TARGET_INSTANCE, 32'd2);
        send_bytes('{8'h00, 8'h00, 8'h00, 8'hFE, 8'h11, 8'hFF});

        // Random phases, each with its own register setting.
        phase_no = 0;
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            phase_no++;
            drain_stream();
            tx_calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (phase_no == 1 || (phase_no > 3 && r < 5)) begin
                // Largest region, cut short later by the next setting.
                write_cfg(REG_REGION_LENGTH, {8'($urandom_range(0, 255)), 24'hFF_FFFF});
                build_region(40, tid_now, region);
                while (region.size() > 3 && $urandom_range(0, 5) != 0)
                    region.delete(region.size() - 1);
                send_bytes(region);
            end else if (phase_no == 2 || (phase_no > 3 && r < 10)) begin
                write_cfg(REG_REGION_LENGTH, {8'($urandom_range(0, 255)), 24'd0});
                repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) size = $urandom_range(8, 60);
                else if (r < 85) size = $urandom_range(1, 7);
                else size = $urandom_range(61, 250);
                value = 32'(size);
                if ($urandom_range(0, 3) == 0) value[31:24] = 8'($urandom_range(0, 255));
                write_cfg(REG_REGION_LENGTH, value);
                if ($urandom_range(0, 9) < 7) begin
                    r = $urandom_range(0, 9);
                    if (r < 4) value = $urandom_range(0, 3);
                    else if (r < 5) value = 254;
                    else value = $urandom_range(0, 254);
                    if ($urandom_range(0, 3) == 0) value[31:8] = 24'($urandom);
                    write_cfg(REG_TARGET_ID, value);
                end
                if ($urandom_range(0, 9) < 7) begin
                    r = $urandom_range(0, 9);
                    if (r < 3) value = 1;
                    else if (r < 5) value = 0;
                    else if (r < 8) value = $urandom_range(2, 4);
                    else if (r < 9) value = 65535;
                    else value = $urandom_range(0, 65535);
                    if ($urandom_range(0, 3) == 0) value[31:16] = 16'($urandom);
                    write_cfg(REG_TARGET_INSTANCE, value);
                end
                repeat ($urandom_range(1, 3)) begin
                    build_region(size, tid_now, region);
                    send_bytes(region);
                    if ($urandom_range(0, 4) == 0) drain_stream();
                end
                // Sometimes stop mid-region so the next setting lands inside a walk.
                if ($urandom_range(0, 3) == 0) begin
                    build_region(size, tid_now, region);
                    while (region.size() > 1 && $urandom_range(0, 2) != 0)
                        region.delete(region.size() - 1);
                    send_bytes(region);
                end
            end
        end

        drain_stream();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
